/* src/pdfm_pkg.sv */
// ----------------------------------------------------------------------------
// PWM duty and frequency meter: shared package
// Result record and fixed constants used by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package pdfm_pkg;

  // Capture mode codes; bit 0 selects rising (1) or falling (0) polarity.
  localparam logic [7:0]  MODE_FALLING  = 8'h04;
  localparam logic [7:0]  MODE_RISING   = 8'h05;

  // Scaling and saturation limits.
  localparam logic [19:0] US_PER_SECOND = 20'd1000000;
  localparam logic [6:0]  PERCENT_SCALE = 7'd100;
  localparam logic [14:0] FIELD15_MAX   = 15'h7FFF;
  localparam logic [15:0] FREQ_MAX      = 16'hFFFF;

  // One result, last field in the lowest bit.
  typedef struct packed {
    logic        clear_timer;
    logic        next_edge_rising;
    logic        period_zero_error;
    logic [15:0] frequency_hz;
    logic [6:0]  duty_percent;
    logic [14:0] period_us;
    logic [14:0] width_us;
    logic        measurement_valid;
  } result_t;

endpackage

/* src/pdfm_front.sv */
// ----------------------------------------------------------------------------
// PWM duty and frequency meter: front end
// Tracks the edge phase, keeps the rise and fall stamps and turns each capture
// into a job: a plain polarity update or a completed width and period pair.
// ----------------------------------------------------------------------------
module pdfm_front import pdfm_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [15:0]               s_tdata,
  output logic                      job_valid,
  input  logic                      job_ready,
  output logic [2*TIMER_BITS+1:0]   job_data
);

  typedef enum logic [2:0] {
    PH_WAIT_RISE = 3'b001,
    PH_WAIT_FALL = 3'b010,
    PH_WAIT_END  = 3'b100
  } phase_t;

  phase_t                phase;
  logic [TIMER_BITS-1:0] rise_stamp;
  logic [TIMER_BITS-1:0] fall_stamp;
  logic [31:0]           cap_ext;
  logic [TIMER_BITS-1:0] stamp;
  logic                  accept;
  logic                  complete;
  logic                  next_rising;
  logic [TIMER_BITS-1:0] wdiff;
  logic [TIMER_BITS-1:0] pdiff;

  // Mask the captured value to the timer width.
  assign cap_ext  = {16'b0, s_tdata};
  assign stamp    = cap_ext[TIMER_BITS-1:0];
  assign s_tready = job_ready;
  assign job_valid = s_tvalid;
  assign accept   = s_tvalid && s_tready;

  // Classify the edge; the tick differences wrap at the timer width.
  always_comb begin
    complete    = 1'b0;
    next_rising = MODE_FALLING[0];
    wdiff       = fall_stamp - rise_stamp;
    pdiff       = stamp - rise_stamp;
    case (phase)
      PH_WAIT_FALL: begin
        next_rising = MODE_RISING[0];
      end
      PH_WAIT_END: begin
        complete    = 1'b1;
        next_rising = MODE_RISING[0];
      end
      default: begin
        next_rising = MODE_FALLING[0];
      end
    endcase
  end

  assign job_data = {complete, next_rising, wdiff, pdiff};

  // Phase and stamp registers advance once per accepted capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT_RISE;
    end else if (accept) begin
      case (phase)
        PH_WAIT_FALL: begin
          fall_stamp <= stamp;
          phase      <= PH_WAIT_END;
        end
        PH_WAIT_END: begin
          phase <= PH_WAIT_RISE;
        end
        default: begin
          rise_stamp <= stamp;
          phase      <= PH_WAIT_FALL;
        end
      endcase
    end
  end

endmodule

/* src/pdfm_queue.sv */
// ----------------------------------------------------------------------------
// PWM duty and frequency meter: job queue
// Two-entry FIFO that lets the front end keep taking captures while the back
// end is busy dividing.
// ----------------------------------------------------------------------------
module pdfm_queue #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/pdfm_div.sv */
// ----------------------------------------------------------------------------
// PWM duty and frequency meter: serial divider
// Restoring divider producing one quotient bit per cycle; done pulses as the
// last bit is registered, with the quotient held until the next start.
// ----------------------------------------------------------------------------
module pdfm_div #(
  parameter int NW  = 23,
  parameter int DVW = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [NW-1:0]  quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DVW-1:0] rem;
  logic [DVW-1:0] dvs;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [DVW:0]   shifted;
  logic           ge;
  logic [DVW:0]   diff;

  // One restoring step: bring down the next dividend bit and trial-subtract.
  assign shifted = {rem, quotient[NW-1]};
  assign ge      = (shifted >= {1'b0, dvs});
  assign diff    = shifted - {1'b0, dvs};

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[DVW-1:0] : shifted[DVW-1:0];
      quotient <= {quotient[NW-2:0], ge};
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

/* src/pdfm_back.sv */
// ----------------------------------------------------------------------------
// PWM duty and frequency meter: back end
// Takes jobs from the queue, converts the tick differences to microseconds,
// runs the duty and frequency divisions on the shared serial divider and
// holds the result register.
// ----------------------------------------------------------------------------
module pdfm_back import pdfm_pkg::*; #(
  parameter int TICKS_PER_US = 2,
  parameter int TIMER_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  logic [2*TIMER_BITS+1:0]  q_data,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output result_t                  m_result
);

  localparam int TW  = TIMER_BITS;
  localparam int NW  = (TW + 7 > 20) ? TW + 7 : 20;

  // Ticks to microseconds by a scaled reciprocal. The reciprocal is rounded up,
  // and its error stays below one part in the divisor for any TW-bit
  // difference, so the product shifted down is the exact floor quotient.
  localparam int              RSH     = TW + $clog2(TICKS_PER_US);
  localparam longint unsigned RECIP   = ((64'd1 << RSH) + 64'(TICKS_PER_US) - 64'd1)
                                        / 64'(TICKS_PER_US);
  localparam logic [TW:0]     RECIP_M = (TW+1)'(RECIP);

  typedef enum logic [4:0] {
    BK_IDLE   = 5'b00001,
    BK_PERIOD = 5'b00010,
    BK_DUTY   = 5'b00100,
    BK_FREQ   = 5'b01000,
    BK_OUT    = 5'b10000
  } bk_state_t;

  bk_state_t      state;
  logic           out_free;
  logic           out_load;
  logic           j_complete;
  logic           j_rising;
  logic [TW-1:0]  j_wdiff;
  logic [TW-1:0]  j_pdiff;
  logic [2*TW:0]  w_prod;
  logic [2*TW:0]  p_prod;
  logic [TW-1:0]  w_calc;
  logic [TW-1:0]  p_calc;
  logic           rising_q;
  logic [TW-1:0]  w_q;
  logic [TW-1:0]  p_q;
  logic [6:0]     duty_q;
  logic [15:0]    freq_q;
  logic           err_q;
  logic           div_start;
  logic [NW-1:0]  div_dividend;
  logic [TW-1:0]  div_divisor;
  logic           div_done;
  logic [NW-1:0]  div_quo;
  logic           p_zero;
  result_t        full_res;
  result_t        edge_res;

  assign j_complete = q_data[2*TW+1];
  assign j_rising   = q_data[2*TW];
  assign j_wdiff    = q_data[2*TW-1:TW];
  assign j_pdiff    = q_data[TW-1:0];
  assign out_free   = !m_tvalid || m_tready;
  assign p_zero     = (p_q == '0);

  // Width and period in microseconds from the wrapped tick differences.
  assign w_prod = (2*TW+1)'(j_wdiff) * (2*TW+1)'(RECIP_M);
  assign p_prod = (2*TW+1)'(j_pdiff) * (2*TW+1)'(RECIP_M);
  assign w_calc = TW'(w_prod >> RSH);
  assign p_calc = TW'(p_prod >> RSH);

  // Both divisions of a measurement divide by the period.
  assign div_divisor = p_q;

  pdfm_div #(
    .NW  (NW),
    .DVW (TW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Queue pop, output load and divider operand selection for each step.
  always_comb begin
    q_ready      = 1'b0;
    out_load     = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    case (state)
      BK_IDLE: begin
        q_ready  = q_valid && (j_complete || out_free);
        out_load = q_valid && !j_complete && out_free;
      end
      BK_PERIOD: begin
        if (!p_zero) begin
          div_start    = 1'b1;
          div_dividend = NW'(w_q) * NW'(PERCENT_SCALE);
        end
      end
      BK_DUTY: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = NW'(US_PER_SECOND);
        end
      end
      BK_OUT: begin
        out_load = out_free;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Result records for a completed measurement and for a plain edge.
  always_comb begin
    full_res                   = '0;
    full_res.measurement_valid = 1'b1;
    full_res.width_us  = (32'(w_q) > 32'(FIELD15_MAX)) ? FIELD15_MAX : 15'(w_q);
    full_res.period_us = (32'(p_q) > 32'(FIELD15_MAX)) ? FIELD15_MAX : 15'(p_q);
    full_res.duty_percent      = duty_q;
    full_res.frequency_hz      = freq_q;
    full_res.period_zero_error = err_q;
    full_res.next_edge_rising  = rising_q;
    full_res.clear_timer       = 1'b1;

    edge_res                  = '0;
    edge_res.next_edge_rising = j_rising;
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        BK_IDLE: begin
          if (q_valid && q_ready) begin
            if (j_complete) begin
              w_q      <= w_calc;
              p_q      <= p_calc;
              rising_q <= j_rising;
              state    <= BK_PERIOD;
            end else begin
              m_result <= edge_res;
            end
          end
        end
        BK_PERIOD: begin
          if (p_zero) begin
            err_q  <= 1'b1;
            duty_q <= '0;
            freq_q <= '0;
            state  <= BK_OUT;
          end else begin
            err_q <= 1'b0;
            state <= BK_DUTY;
          end
        end
        BK_DUTY: begin
          if (div_done) begin
            duty_q <= (div_quo > NW'(PERCENT_SCALE)) ? PERCENT_SCALE : div_quo[6:0];
            state  <= BK_FREQ;
          end
        end
        BK_FREQ: begin
          if (div_done) begin
            freq_q <= (div_quo > NW'(FREQ_MAX)) ? FREQ_MAX : div_quo[15:0];
            state  <= BK_OUT;
          end
        end
        BK_OUT: begin
          if (out_free) begin
            m_result <= full_res;
            state    <= BK_IDLE;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/pwm_duty_frequency_meter_top.sv */
// A rising or falling edge passes the job queue and the back end idle state into the
// result register; a completing edge also steps through the period check, the duty and
// frequency divisions (NW = max(TIMER_BITS+7, 20) bits, 23 at defaults) and the output
// state, and skips both divisions when the period is zero. Completing edges are paced
// by the duty and frequency divisions on the shared one-bit-per-cycle divider; other
// edges enter a two-entry job queue one per cycle while the queue has room.
// Reset: synchronous, active high; clears the edge phase, queue and result valid.
// ----------------------------------------------------------------------------
// PWM duty and frequency meter: top level
// Measures high width, period, duty cycle and frequency from edge captures.
// ----------------------------------------------------------------------------
module pwm_duty_frequency_meter_top import pdfm_pkg::*; #(
  parameter int TICKS_PER_US = 2,
  parameter int TIMER_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] capture_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [0] measurement_valid, [15:1] width_us,
                                 // [30:16] period_us, [37:31] duty_percent,
                                 // [53:38] frequency_hz, [54] period_zero_error,
                                 // [55] next_edge_rising, [56] clear_timer, zero above
);

  localparam int JW = 2 * TIMER_BITS + 2;

  logic          f_valid;
  logic          f_ready;
  logic [JW-1:0] f_data;
  logic          q_valid;
  logic          q_ready;
  logic [JW-1:0] q_data;
  result_t       result;

  // Edge classification and stamp keeping.
  pdfm_front #(
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_data  (f_data)
  );

  // Job queue between front and back.
  pdfm_queue #(
    .WIDTH (JW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // Division sequence and result register.
  pdfm_back #(
    .TICKS_PER_US (TICKS_PER_US),
    .TIMER_BITS   (TIMER_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (result)
  );

  assign m_tdata = {7'b0, result};

endmodule
